// ----- rtl/core/spg_pkg.sv -----
// Package for the scaler phase generator: sizes, register codes and the
// structs passed between the configuration block, the sample cells and the word engine.
// No dependencies.
`default_nettype none

package spg_pkg;

  localparam int SAMPLES_PER_WORD = 4;
  localparam int STEP_FRAC_BITS   = 16;
  localparam int PHASE_BITS       = 6;

  localparam int WIDTH_W  = 13;
  localparam int STEP_W   = 24;
  localparam int ACC_W    = 25;
  localparam int WP_W     = 13;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 12;

  localparam int PHASE_STRIDE = 6;
  localparam int INDEX_STRIDE = 3;
  localparam int PHASES_W     = 24;
  localparam int INDICES_W    = 12;
  localparam int ENABLES_W    = 4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [WIDTH_W-1:0] WIDTH_IN_RST   = WIDTH_W'(1920);
  localparam logic [WIDTH_W-1:0] WIDTH_OUT_RST  = WIDTH_W'(1920);
  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST = STEP_W'(65536);
  localparam int WORDS_RST = (1920 + SAMPLES_PER_WORD - 1) / SAMPLES_PER_WORD;
  localparam logic [CNT_W-1:0]   LAST_INDEX_RST = CNT_W'(WORDS_RST - 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH_IN   = 2'd0,
    REG_WIDTH_OUT  = 2'd1,
    REG_PIXEL_STEP = 2'd2
  } cfg_reg_e;

  // Settings the word engine needs, with the last-word index precomputed
  typedef struct packed {
    logic [WIDTH_W-1:0] width_out;
    logic [STEP_W-1:0]  pixel_step;
    logic [CNT_W-1:0]   last_index;
  } cfg_t;

  // Running state handed from one sample cell to the next
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [WP_W-1:0]  wp;
    logic [IDX_W-1:0] idx;
  } sample_state_t;

  typedef struct packed {
    logic [PHASES_W-1:0]  sample_phases;
    logic [INDICES_W-1:0] sample_indices;
    logic [ENABLES_W-1:0] sample_enables;
    logic                 last_word;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/spg_channels.sv -----
// Valid/ready channel interfaces for the scaler phase generator: the tick
// request channel and the control word channel. Depends on spg_pkg.
`default_nettype none

interface spg_tick_if;
  import spg_pkg::*;
  logic valid;
  logic ready;
  logic start_line;

  modport source (output valid, output start_line, input ready);
  modport sink   (input valid, input start_line, output ready);
endinterface

interface spg_word_if;
  import spg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [PHASES_W-1:0]  sample_phases;
  logic [INDICES_W-1:0] sample_indices;
  logic [ENABLES_W-1:0] sample_enables;
  logic                 last_word;

  modport source (output valid, output sample_phases, output sample_indices,
                  output sample_enables, output last_word, input ready);
  modport sink   (input valid, input sample_phases, input sample_indices,
                  input sample_enables, input last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/scaler_phase_generator.sv -----
// Scaler phase generator top level: request and word handshakes around the
// configuration block and the word engine. Depends on spg_pkg, spg_channels,
// spg_cfg_regs and spg_word_engine.
//
// Each request on tick yields one control word on word, carrying the phase
// and input index of every sample of the column, the sample enables and the
// last-word flag. The block takes one request per clock when word is not
// stalled: a request is held in the input register while the chain of sample
// cells works out its whole column, and moves into the result register, from
// which the word is presented, once that register is free. The sample cell
// chain, which closes the accumulator update combinationally, sets that
// rate. Write the configuration only while no request is in flight.
`default_nettype none

module scaler_phase_generator (
  input  logic                           clk,
  input  logic                           rst,
  spg_tick_if.sink                       tick,
  spg_word_if.source                     word,
  input  logic                           cfg_wr_en,
  input  logic [spg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spg_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    s1_valid;
  logic    s1_start;
  logic    out_valid;
  logic    out_free;
  logic    take;

  spg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign out_free   = !out_valid || word.ready;
  assign take       = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_start <= tick.start_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (word.ready) begin
      out_valid <= 1'b0;
    end
  end

  spg_word_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .start_line (s1_start),
    .cfg        (cfg),
    .result     (result)
  );

  assign word.valid          = out_valid;
  assign word.sample_phases  = result.sample_phases;
  assign word.sample_indices = result.sample_indices;
  assign word.sample_enables = result.sample_enables;
  assign word.last_word      = result.last_word;

  // A request moved into the engine shows up as a word next cycle
  a_take_gives_word: assert property (@(posedge clk) disable iff (rst)
    take |=> word.valid)
    else $error("word not presented after engine took a request");

  // Requests stall only when both the input and the result register are held
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> (s1_valid && out_valid && !word.ready))
    else $error("tick stalled with room in the pipeline");

  // The first sample of a line starts at index zero and phase zero
  a_line_start_clean: assert property (@(posedge clk) disable iff (rst)
    (take && s1_start) |=> (word.sample_indices[IDX_W-1:0] == '0 &&
                            word.sample_phases[PHASE_BITS-1:0] == '0))
    else $error("line start did not clear the sample state");

endmodule

`default_nettype wire

// ----- rtl/core/spg_cfg_regs.sv -----
// Configuration registers of the scaler phase generator and the derived
// last-word index. Depends on spg_pkg.
`default_nettype none

module spg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [spg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output spg_pkg::cfg_t                  cfg
);
  import spg_pkg::*;

  logic [WIDTH_W-1:0] width_in;
  logic [WIDTH_W-1:0] width_out;
  logic [STEP_W-1:0]  pixel_step;
  logic [CNT_W-1:0]   last_index;
  logic [CNT_W-1:0]   last_index_next;
  logic [WIDTH_W-1:0] widest;
  logic [WIDTH_W:0]   rounded;
  logic [WIDTH_W:0]   words;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in   <= WIDTH_IN_RST;
      width_out  <= WIDTH_OUT_RST;
      pixel_step <= PIXEL_STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e'(cfg_addr))
        REG_WIDTH_IN:   width_in   <= cfg_wdata[WIDTH_W-1:0];
        REG_WIDTH_OUT:  width_out  <= cfg_wdata[WIDTH_W-1:0];
        REG_PIXEL_STEP: pixel_step <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Words per line is ceil(max width / samples per word), at least one
  always_comb begin
    widest  = (width_in > width_out) ? width_in : width_out;
    rounded = {1'b0, widest} + (WIDTH_W+1)'(SAMPLES_PER_WORD - 1);
    words   = rounded / (WIDTH_W+1)'(SAMPLES_PER_WORD);
    if (words == '0) begin
      last_index_next = '0;
    end else begin
      last_index_next = CNT_W'(words - (WIDTH_W+1)'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= LAST_INDEX_RST;
    end else begin
      last_index <= last_index_next;
    end
  end

  assign cfg.width_out  = width_out;
  assign cfg.pixel_step = pixel_step;
  assign cfg.last_index = last_index;

endmodule

`default_nettype wire

// ----- rtl/core/spg_sample_cell.sv -----
// One sample slot of the phase generator: phase tap, pixel consume and
// step add on the running accumulator. Depends on spg_pkg.
`default_nettype none

module spg_sample_cell (
  input  spg_pkg::sample_state_t          st_in,
  input  logic [spg_pkg::STEP_W-1:0]      pixel_step,
  input  logic [spg_pkg::WIDTH_W-1:0]     width_out,
  output spg_pkg::sample_state_t          st_out,
  output logic [spg_pkg::PHASE_BITS-1:0]  phase,
  output logic [spg_pkg::IDX_W-1:0]       index,
  output logic                            enable
);
  import spg_pkg::*;

  localparam logic [ACC_W-1:0] ONE_UNIT = ACC_W'(1) << STEP_FRAC_BITS;

  sample_state_t after;
  logic          consume;

  always_comb begin
    consume = |st_in.acc[ACC_W-1:STEP_FRAC_BITS];
    after   = st_in;
    // Drop one input pixel if the integer part is nonzero
    if (consume) begin
      after.acc = st_in.acc - ONE_UNIT;
      after.idx = st_in.idx + IDX_W'(1);
    end
    enable = ~|after.acc[ACC_W-1:STEP_FRAC_BITS] && (st_in.wp < width_out);
    st_out = after;
    if (enable) begin
      st_out.acc = after.acc + ACC_W'(pixel_step);
      st_out.wp  = after.wp + WP_W'(1);
    end
    phase = st_in.acc[STEP_FRAC_BITS-1 -: PHASE_BITS];
    index = after.idx;
  end

endmodule

`default_nettype wire

// ----- rtl/core/spg_word_engine.sv -----
// Word engine of the phase generator: line state registers, the chain of
// sample cells and the result register. Depends on spg_pkg, spg_sample_cell.
`default_nettype none

module spg_word_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             start_line,
  input  spg_pkg::cfg_t    cfg,
  output spg_pkg::result_t result
);
  import spg_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [WP_W-1:0]  wp;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] cnt_eff;
  result_t          result_next;

  sample_state_t               chain   [SAMPLES_PER_WORD+1];
  logic [PHASE_BITS-1:0]       phase_s [SAMPLES_PER_WORD];
  logic [IDX_W-1:0]            index_s [SAMPLES_PER_WORD];
  logic [SAMPLES_PER_WORD-1:0] enable_s;

  // A line start clears the state ahead of this word
  always_comb begin
    if (start_line) begin
      chain[0] = '0;
      cnt_eff  = '0;
    end else begin
      chain[0].acc = acc;
      chain[0].wp  = wp;
      chain[0].idx = idx;
      cnt_eff      = cnt;
    end
  end

  for (genvar s = 0; s < SAMPLES_PER_WORD; s++) begin : g_cell
    spg_sample_cell u_cell (
      .st_in      (chain[s]),
      .pixel_step (cfg.pixel_step),
      .width_out  (cfg.width_out),
      .st_out     (chain[s+1]),
      .phase      (phase_s[s]),
      .index      (index_s[s]),
      .enable     (enable_s[s])
    );
  end

  always_comb begin
    idx_next = chain[SAMPLES_PER_WORD].idx;
    if (idx_next >= IDX_W'(SAMPLES_PER_WORD)) begin
      idx_next = idx_next - IDX_W'(SAMPLES_PER_WORD);
    end
    result_next = '0;
    for (int s = 0; s < SAMPLES_PER_WORD; s++) begin
      result_next.sample_phases[s*PHASE_STRIDE +: PHASE_BITS] = phase_s[s];
      result_next.sample_indices[s*INDEX_STRIDE +: IDX_W]     = index_s[s];
      result_next.sample_enables[s]                           = enable_s[s];
    end
    result_next.last_word = (cnt_eff == cfg.last_index);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      wp  <= '0;
      idx <= '0;
      cnt <= '0;
    end else if (take) begin
      acc <= chain[SAMPLES_PER_WORD].acc;
      wp  <= chain[SAMPLES_PER_WORD].wp;
      idx <= idx_next;
      cnt <= cnt_eff + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for scaler_phase_generator: drives tick requests and register writes,
// predicts every control word and checks each word on the word channel.
// Depends on spg_pkg, spg_channels and the scaler_phase_generator RTL.
module testbench;
  import spg_pkg::*;

  typedef struct {
    bit                 reconfig;
    logic [WIDTH_W-1:0] w_in;
    logic [WIDTH_W-1:0] w_out;
    logic [STEP_W-1:0]  step;
    logic               start;
    bit                 typed;
    result_t            word;
  } step_row_t;

  localparam result_t NO_WORD = '0;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  spg_tick_if tick_ch ();
  spg_word_if word_ch ();

  scaler_phase_generator dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .word      (word_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's settings and line state
  logic [WIDTH_W-1:0] cur_width_in  = WIDTH_IN_RST;
  logic [WIDTH_W-1:0] cur_width_out = WIDTH_OUT_RST;
  logic [STEP_W-1:0]  cur_step      = PIXEL_STEP_RST;
  logic [ACC_W-1:0]   line_acc      = '0;
  logic [WP_W-1:0]    out_count     = '0;
  logic [IDX_W-1:0]   arr_idx       = '0;
  logic [CNT_W-1:0]   word_count    = '0;

  result_t pending_words [$];
  int      mismatch_count = 0;
  int      gap_pct        = 0;
  int      stall_pct      = 0;

  step_row_t directed_rows [23] = '{
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b1, 1'b1, {24'h000000, 12'h688, 4'hF, 1'b0}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b1, {24'h000000, 12'hFAC, 4'hF, 1'b0}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b1, {24'h000000, 12'hFAC, 4'hF, 1'b0}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b1, 1'b1, {24'h000000, 12'h688, 4'hF, 1'b0}},
    '{1'b1, 13'd1,    13'd1,    24'h010000, 1'b1, 1'b1, {24'h000000, 12'h248, 4'h1, 1'b1}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b1, 13'd0,    13'd0,    24'h010000, 1'b1, 1'b1, {24'h000000, 12'h000, 4'h0, 1'b1}},
    '{1'b1, 13'd0,    13'd3,    24'd0,      1'b1, 1'b1, {24'h000000, 12'h000, 4'h7, 1'b1}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b1, 13'd8,    13'd4096, 24'h008000, 1'b1, 1'b1, {24'h800800, 12'h240, 4'hF, 1'b0}},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b1, 13'd4096, 13'd1,    24'hFFFFFF, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b1, 13'd4096, 13'd4096, 24'h000001, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b1, 13'd5,    13'd7,    24'h018000, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b0, 1'b0, NO_WORD},
    '{1'b0, 13'd0,    13'd0,    24'd0,      1'b1, 1'b0, NO_WORD}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int line_words();
    int widest;
    int words;
    widest = (cur_width_in > cur_width_out) ? int'(cur_width_in) : int'(cur_width_out);
    words  = (widest + SAMPLES_PER_WORD - 1) / SAMPLES_PER_WORD;
    if (words == 0) words = 1;
    return words;
  endfunction

  // Advance the line state by one column and build its control word
  function automatic result_t predict_word(input logic start);
    result_t r;
    r = '0;
    if (start) begin
      line_acc   = '0;
      out_count  = '0;
      arr_idx    = '0;
      word_count = '0;
    end
    for (int s = 0; s < SAMPLES_PER_WORD; s++) begin
      r.sample_phases[s*PHASE_STRIDE +: PHASE_BITS] = line_acc[STEP_FRAC_BITS-1 -: PHASE_BITS];
      if (line_acc[ACC_W-1:STEP_FRAC_BITS] != '0) begin
        line_acc = line_acc - (ACC_W'(1) << STEP_FRAC_BITS);
        arr_idx  = arr_idx + 1'b1;
      end
      if (line_acc[ACC_W-1:STEP_FRAC_BITS] == '0 && out_count < cur_width_out) begin
        line_acc  = line_acc + ACC_W'(cur_step);
        out_count = out_count + 1'b1;
        r.sample_enables[s] = 1'b1;
      end
      r.sample_indices[s*INDEX_STRIDE +: IDX_W] = arr_idx;
    end
    if (arr_idx >= IDX_W'(SAMPLES_PER_WORD)) arr_idx = arr_idx - IDX_W'(SAMPLES_PER_WORD);
    r.last_word = (word_count == CNT_W'(line_words() - 1));
    word_count  = word_count + 1'b1;
    return r;
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    case ($urandom_range(19))
      0:       return WIDTH_W'(4096);
      1:       return WIDTH_W'($urandom_range(1, 4096));
      default: return WIDTH_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Drain the block, then load all three registers
  task automatic load_settings(input logic [WIDTH_W-1:0] w_in, input logic [WIDTH_W-1:0] w_out,
                               input logic [STEP_W-1:0] step);
    tick_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_WIDTH_IN, CFG_DATA_W'(w_in));
    cur_width_in = w_in;
    write_reg(REG_WIDTH_OUT, CFG_DATA_W'(w_out));
    cur_width_out = w_out;
    write_reg(REG_PIXEL_STEP, CFG_DATA_W'(step));
    cur_step = step;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_request(input logic start, input bit use_typed, input result_t typed_word);
    result_t predicted;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.start_line <= start;
    do @(posedge clk); while (!tick_ch.ready);
    predicted = predict_word(start);
    pending_words.push_back(use_typed ? typed_word : predicted);
  endtask

  initial begin
    word_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      word_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : word_check
    result_t want;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing pending: phases %h indices %h",
                                  word_ch.sample_phases, word_ch.sample_indices));
      end else begin
        want = pending_words.pop_front();
        if (word_ch.sample_phases !== want.sample_phases)
          report_mismatch($sformatf("sample_phases %h, want %h",
                                    word_ch.sample_phases, want.sample_phases));
        if (word_ch.sample_indices !== want.sample_indices)
          report_mismatch($sformatf("sample_indices %h, want %h",
                                    word_ch.sample_indices, want.sample_indices));
        if (word_ch.sample_enables !== want.sample_enables)
          report_mismatch($sformatf("sample_enables %h, want %h",
                                    word_ch.sample_enables, want.sample_enables));
        if (word_ch.last_word !== want.last_word)
          report_mismatch($sformatf("last_word %b, want %b",
                                    word_ch.last_word, want.last_word));
      end
    end
  end

  initial begin : stimulus
    int      random_items;
    int      phase_no;
    int      lines;
    int      words;
    int      len;
    bit      broken;
    logic    start;
    logic [STEP_W-1:0] step;

    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.start_line = 1'b0;
    random_items       = 0;
    phase_no           = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig)
        load_settings(directed_rows[i].w_in, directed_rows[i].w_out, directed_rows[i].step);
      send_request(directed_rows[i].start, directed_rows[i].typed, directed_rows[i].word);
    end

    // Keep ticking a one-word line well past its end
    load_settings(WIDTH_W'(1), WIDTH_W'(1), STEP_W'(65536));
    for (int k = 0; k < 40; k++) send_request(k == 0, 1'b0, NO_WORD);

    while (random_items < 1000) begin
      case (phase_no % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 71; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 71; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      case ($urandom_range(9))
        0:       step = '1;
        1:       step = STEP_W'(1);
        2, 3:    step = STEP_W'($urandom_range(1, 24'hFFFFFF));
        default: step = STEP_W'($urandom_range(24'h004000, 24'h040000));
      endcase
      load_settings(pick_width(), pick_width(), step);
      lines = $urandom_range(2, 6);
      for (int l = 0; l < lines; l++) begin
        words  = line_words();
        broken = ($urandom_range(99) < 20);
        // Cut wide lines short so that most of the run stays on small sizes
        if (broken) len = $urandom_range(1, ((words > 64) ? 64 : words) + 4);
        else        len = (words > 64) ? $urandom_range(1, 64) : words;
        for (int k = 0; k < len; k++) begin
          if (k == 0) start = broken ? 1'($urandom_range(1)) : 1'b1;
          else        start = broken && ($urandom_range(9) == 0);
          send_request(start, 1'b0, NO_WORD);
          random_items++;
        end
      end
      phase_no++;
    end

    tick_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/spg_pkg.sv
rtl/core/spg_channels.sv
rtl/core/spg_cfg_regs.sv
rtl/core/spg_sample_cell.sv
rtl/core/spg_word_engine.sv
rtl/core/scaler_phase_generator.sv
verif/testbench.sv
